@@ src/glef_pkg.sv @@
package glef_pkg;

    // Pixel and line store geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LINE_W    = 2 * PIX_W;

    // Configuration registers.
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(2048);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

    // The output position never reaches MAX_WIDTH * 65535, which fits in 27 bits.
    localparam int POS_W     = 27;
    localparam int DIV_CNT_W = $clog2(POS_W + 1);

    // Gray conversion weights, unsigned Q0.24.
    localparam int COEF_W    = 24;
    localparam int ACC_W     = COEF_W + PIX_W;
    localparam logic [COEF_W-1:0] COEF_R = COEF_W'(5016388);
    localparam logic [COEF_W-1:0] COEF_G = COEF_W'(9848226);
    localparam logic [COEF_W-1:0] COEF_B = COEF_W'(1912603);

    // Laplacian sum range is -1020 .. 1020.
    localparam int SUM_W     = PIX_W + 3;

    // Output queue.
    localparam int FIFO_DEPTH = 3;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic warm;
        logic has_left;
        logic has_right;
        logic has_up;
        logic has_down;
        logic last;
    } t_win_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_result;

endpackage

@@ src/gray_laplacian_edge_filter.sv @@
// Accepted items are registered in the window stage, whose results the output queue holds.
// Throughput: one item per cycle while o_stall is low; the simple dual-port line store
// is read at accept and written from the window stage. Writing image_width mid-frame
// stalls the input while a bit-serial divider rebuilds the output column and row.
// Reset (synchronous, active low) restores width 2048 and height 1, clears counters,
// window and output queue; the line store contents are left as they are.
module gray_laplacian_edge_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [glef_pkg::PIX_W-1:0]    i_red,
    input  logic [glef_pkg::PIX_W-1:0]    i_green,
    input  logic [glef_pkg::PIX_W-1:0]    i_blue,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [glef_pkg::PIX_W-1:0]    o_edge_value,
    output logic                          o_frame_last,
    input  logic                          i_cfg_we,
    input  logic [glef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [glef_pkg::CFG_W-1:0]    i_cfg_data
);
    import glef_pkg::*;

    // Configuration registers and their effective values.
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    // Input side counters. The input row only matters up to two.
    logic [COL_W-1:0]    r_col;
    logic [1:0]          r_row;
    // Output position: raster index plus its column and row for the current width.
    logic [POS_W-1:0]    r_p;
    logic [COL_W-1:0]    r_ox;
    logic [POS_W-1:0]    r_oy;

    logic [COL_W-1:0]    n_col;
    logic [1:0]          n_row;
    logic [POS_W-1:0]    n_p;
    logic [COL_W-1:0]    n_ox;
    logic [POS_W-1:0]    n_oy;

    // Divider that rebuilds column and row after a width change.
    logic                 r_div_busy;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [POS_W-1:0]     r_div_num;
    logic [WIDTH_W-1:0]   r_div_rem;
    logic [WIDTH_W-1:0]   div_trial;
    logic                 div_ge;
    logic [WIDTH_W-1:0]   div_rem_nxt;
    logic [POS_W-1:0]     div_num_nxt;

    // Accept stage.
    logic                 acc;
    logic [COL_W-1:0]     col_c;
    logic [ACC_W-1:0]     gray_acc;
    logic [PIX_W-1:0]     gray;
    t_win_ctl             ctl_now;

    // Window stage.
    logic                 r_s1_vld;
    t_win_ctl             r_s1_ctl;
    logic [COL_W-1:0]     r_s1_col;
    logic [PIX_W-1:0]     r_s1_gray;
    logic                 r_byp_sel;
    logic [LINE_W-1:0]    r_byp_data;
    logic [LINE_W-1:0]    ram_rdata;
    logic [LINE_W-1:0]    line_cur;
    logic [PIX_W-1:0]     a_old;
    logic [PIX_W-1:0]     b_old;

    logic [PIX_W-1:0]     r_win_left;
    logic [PIX_W-1:0]     r_win_center;
    logic [PIX_W-1:0]     r_win_up;
    logic [PIX_W-1:0]     r_win_down;

    logic [PIX_W-1:0]     nb_left;
    logic [PIX_W-1:0]     nb_right;
    logic [PIX_W-1:0]     nb_up;
    logic [PIX_W-1:0]     nb_down;
    logic [SUM_W-1:0]     lap_sum;
    logic [SUM_W-1:0]     lap_abs;
    t_result              res;

    // Output queue.
    t_result              r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_cnt;
    logic                 push;
    logic                 pop;
    logic [CNT_W:0]       pending;

    // Width 0 behaves as 1, anything above the line store size as the full size.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    // The input is held off while the divider runs, and whenever the queue would be full
    // with the window stage's result pushed, so might not take the new item's result.
    assign push    = r_s1_vld && r_s1_ctl.warm;
    assign pop     = o_valid && !i_stall;
    assign pending = {1'b0, r_cnt} + {{CNT_W{1'b0}}, push};
    assign o_stall = r_div_busy || (pending > (CNT_W + 1)'(FIFO_DEPTH - 1));
    assign acc     = i_valid && !o_stall;

    // Gray conversion: three constant products, keep the integer part; a command item gives zero.
    assign gray_acc = ACC_W'(COEF_R) * ACC_W'(i_red)
                    + ACC_W'(COEF_G) * ACC_W'(i_green)
                    + ACC_W'(COEF_B) * ACC_W'(i_blue);
    assign gray     = i_command ? '0 : gray_acc[ACC_W-1:ACC_W-PIX_W];

    // Control for this item, all from counters. A column left over from a wider frame
    // wraps to zero. The frame ends once the output position reaches width*height-1,
    // which with the column below the width means row past the end, or last row and
    // last column.
    always_comb begin
        col_c = ({1'b0, r_col} >= w_eff) ? '0 : r_col;

        ctl_now.warm      = (r_row == 2'd2) || ((r_row == 2'd1) && (col_c != '0));
        ctl_now.has_left  = (r_ox != '0);
        ctl_now.has_right = (({1'b0, r_ox} + WIDTH_W'(1)) < w_eff);
        ctl_now.has_up    = (r_oy != '0);
        ctl_now.has_down  = ((r_oy + POS_W'(1)) < POS_W'(h_eff));
        ctl_now.last      = (r_oy >= POS_W'(h_eff))
                         || ((r_oy == POS_W'(h_eff - HEIGHT_W'(1)))
                             && ({1'b0, r_ox} == (w_eff - WIDTH_W'(1))));

        n_p   = r_p;
        n_ox  = r_ox;
        n_oy  = r_oy;
        n_col = r_col;
        n_row = r_row;

        if (ctl_now.warm && ctl_now.last) begin
            n_p   = '0;
            n_ox  = '0;
            n_oy  = '0;
            n_col = '0;
            n_row = '0;
        end else begin
            if (ctl_now.warm) begin
                n_p = r_p + POS_W'(1);
                if (({1'b0, r_ox} + WIDTH_W'(1)) == w_eff) begin
                    n_ox = '0;
                    n_oy = r_oy + POS_W'(1);
                end else begin
                    n_ox = r_ox + COL_W'(1);
                end
            end
            if (({1'b0, col_c} + WIDTH_W'(1)) >= w_eff) begin
                n_col = '0;
                n_row = (r_row == 2'd2) ? r_row : r_row + 2'd1;
            end else begin
                n_col = col_c + COL_W'(1);
            end
        end
    end

    // Restoring division of the output index by the width, one quotient bit a cycle.
    assign div_trial   = {r_div_rem[COL_W-1:0], r_div_num[POS_W-1]};
    assign div_ge      = (div_trial >= w_eff);
    assign div_rem_nxt = div_ge ? (div_trial - w_eff) : div_trial;
    assign div_num_nxt = {r_div_num[POS_W-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_p        <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // At the start of a frame the column and row are zero for any width.
            if (i_cfg_we && (i_cfg_index == REG_IMAGE_WIDTH) && (r_p != '0)) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DIV_CNT_W'(POS_W);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(1)) begin
                    r_div_busy <= 1'b0;
                    r_ox       <= div_rem_nxt[COL_W-1:0];
                    r_oy       <= div_num_nxt;
                end
            end else if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
                r_p   <= n_p;
                r_ox  <= n_ox;
                r_oy  <= n_oy;
            end
        end
    end

    // Divider datapath needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cfg_we && (i_cfg_index == REG_IMAGE_WIDTH)) begin
            r_div_num <= r_p;
            r_div_rem <= '0;
        end else if (r_div_busy) begin
            r_div_num <= div_num_nxt;
            r_div_rem <= div_rem_nxt;
        end
    end

    // Both line stores share one memory word per column: {one row back, two rows back}.
    // The item is read at accept time and written back from the window stage.
    glef_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata ({r_s1_gray, a_old}),
        .i_raddr (col_c),
        .o_rdata (ram_rdata)
    );

    // When the window stage writes the column that is being read, the memory returns
    // the old word, so the new word is forwarded instead.
    assign line_cur = r_byp_sel ? r_byp_data : ram_rdata;
    assign a_old    = line_cur[LINE_W-1:PIX_W];
    assign b_old    = line_cur[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_byp_sel <= 1'b0;
        end else begin
            r_s1_vld  <= acc;
            r_byp_sel <= acc && r_s1_vld && (r_s1_col == col_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ctl   <= ctl_now;
            r_s1_col   <= col_c;
            r_s1_gray  <= gray;
            r_byp_data <= {r_s1_gray, a_old};
        end
    end

    // The window shifts once per item: the center moves left, the word from one row
    // back becomes the center, two rows back becomes up, and the new pixel is down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_center <= '0;
            r_win_up     <= '0;
            r_win_down   <= '0;
        end else if (r_s1_vld) begin
            r_win_left   <= r_win_center;
            r_win_center <= a_old;
            r_win_up     <= b_old;
            r_win_down   <= r_s1_gray;
        end
    end

    // Neighbors outside the frame take the center value.
    always_comb begin
        nb_left  = r_s1_ctl.has_left  ? r_win_left : r_win_center;
        nb_right = r_s1_ctl.has_right ? a_old      : r_win_center;
        nb_up    = r_s1_ctl.has_up    ? r_win_up   : r_win_center;
        nb_down  = r_s1_ctl.has_down  ? r_win_down : r_win_center;

        lap_sum = {1'b0, r_win_center, 2'b00}
                - SUM_W'(nb_left) - SUM_W'(nb_right) - SUM_W'(nb_up) - SUM_W'(nb_down);
        lap_abs = lap_sum[SUM_W-1] ? (SUM_W'(0) - lap_sum) : lap_sum;

        res.edge_value = (lap_abs[SUM_W-1:PIX_W] != '0) ? {PIX_W{1'b1}}
                                                         : lap_abs[PIX_W-1:0];
        res.frame_last = r_s1_ctl.last;
    end

    // Output queue of three results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign o_valid      = (r_cnt != '0);
    assign o_edge_value = r_fifo[r_rd_ptr].edge_value;
    assign o_frame_last = r_fifo[r_rd_ptr].frame_last;

    // The stall rule must keep the queue from being written while full, unless it pops too.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_cnt < CNT_W'(FIFO_DEPTH)))
        else $error("output queue written while full");

    // Outside a divider run the output column is always inside the current width.
    a_column_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_div_busy |-> ({1'b0, r_ox} < w_eff))
        else $error("output column not below the width");

    // Position zero always means column zero and row zero.
    a_origin_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p == '0) |-> ((r_ox == '0) && (r_oy == '0)))
        else $error("output position and column/row disagree");

    // The last output of a frame sends every counter back to the frame start.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ctl_now.warm && ctl_now.last)
            |=> ((r_p == '0) && (r_col == '0) && (r_row == '0)))
        else $error("counters not cleared after the last output of a frame");

endmodule

@@ src/glef_ram.sv @@
module glef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Simple dual port: a read in the same cycle as a write returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
